// File: src/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 8;
   localparam int CSR_IDX_BITS     = 3;
   localparam int CSR_DATA_BITS    = 24;
   localparam int DIST_MAX         = 131071;

   localparam logic [CSR_IDX_BITS-1:0] REG_GOAL_X   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_GOAL_Y   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_X  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_Y  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_HD = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_MPC      = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN     = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_RADIUS   = 3'd7;

   // CORDIC arctangent table, 2^32 units per turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction
endpackage

// File: src/differential_drive_odometry_core.sv
`timescale 1ns / 1ps
// A sample runs seven serial multiplies, a CORDIC rotation, a square root and two setup
// states before response valid; a restart runs two squares and the square root. One
// transaction at a time; the next request is taken the cycle after the response is
// accepted. Synchronous active-high reset loads the default registers, pose (0, 0, one
// eighth turn), zero reference counts and a clear arrival flag.
module differential_drive_odometry_core #(
   parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // left_count[31:0], right_count[63:32]
   input  logic         req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // pos_x, pos_y, heading[15:0], goal_distance, arrived
   input  logic         csr_we,
   input  logic [ddo_pkg::CSR_IDX_BITS-1:0]  csr_idx,
   input  logic [ddo_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import ddo_pkg::*;

   localparam int DFRAC = (FRAC_BITS < 14) ? FRAC_BITS : 14;
   localparam int SH    = 46 - FRAC_BITS;
   localparam int DLIM  = 17 + DFRAC;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_MUL1 = 4'd1, ST_MUL2 = 4'd2,
      ST_GAIN = 4'd3, ST_TRIG = 4'd4, ST_MX = 4'd5, ST_MY = 4'd6,
      ST_POS = 4'd7, ST_SQX = 4'd8, ST_SQY = 4'd9, ST_ROOT = 4'd10,
      ST_OUT = 4'd11;

   logic [3:0] st_ff, st_in;
   logic signed [15:0] goal_x_ff, goal_y_ff, start_x_ff, start_y_ff;
   logic [ANGLE_BITS-1:0] start_hd_ff, hd_ff, hd_in, mid_ff, mid_in;
   logic [23:0] mpc_ff, gain_ff;
   logic [15:0] radius_ff;
   logic [31:0] prev_l_ff, prev_r_ff, lc_ff, rc_ff;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic arr_ff, arr_in;
   logic signed [63:0] dl_ff, dl_in, dr_ff, dr_in, trav_ff, trav_in;
   logic signed [63:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [63:0] sq_ff, sq_in;
   logic [16:0] goal_dist;
   logic sat_ff, sat_in;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [ANGLE_BITS-1:0] rsp_hd_ff;
   logic [16:0] rsp_d_ff;
   logic rsp_a_ff, rsp_v_ff, rsp_v_in;

   // Shared multiplier operands
   logic mul_start, mul_done;
   logic signed [63:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [97:0] mul_p;
   logic cor_start, cor_done;
   logic signed [33:0] cos_v, sin_v;
   logic sq_start, sq_done;
   logic [31:0] root_v;

   ddo_serial_mul #(.A_BITS(64), .B_BITS(34), .P_BITS(98)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p));
   ddo_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(mid_in),
      .done(cor_done), .cos_q30(cos_v), .sin_q30(sin_v));
   ddo_isqrt #(.IN_BITS(64)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_ff),
      .done(sq_done), .root(root_v));

   logic req_fire, rsp_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (st_ff == ST_IDLE) && !rsp_v_ff;

   // Signed abs of goal error, and helpers
   logic signed [63:0] ex_s, ey_s, ax, ay, pstep, wide_sum, trav_sat;
   logic signed [97:0] rnd;
   logic [63:0] p_gain;
   assign ex_s = 64'(goal_x_ff) * (64'sd1 <<< FRAC_BITS) - 64'(x_ff);
   assign ey_s = 64'(goal_y_ff) * (64'sd1 <<< FRAC_BITS) - 64'(y_ff);
   assign ax   = ex_ff[63] ? -ex_ff : ex_ff;
   assign ay   = ey_ff[63] ? -ey_ff : ey_ff;
   assign rnd  = (mul_p + (98'sd1 <<< (SH - 1))) >>> SH;
   assign pstep = 64'(rnd);
   assign wide_sum = dl_ff + dr_ff;
   assign p_gain = 64'(mul_p);
   always_comb begin
      trav_sat = wide_sum >>> 1;
      if (trav_sat > 64'sd4294967295) trav_sat = 64'sd4294967295;
      if (trav_sat < -64'sd4294967296) trav_sat = -64'sd4294967296;
   end

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      begin
         if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
         else if (v < -64'sd2147483648) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction

   // Sequencer
   always_comb begin
      st_in = st_ff; hd_in = hd_ff; mid_in = mid_ff; x_in = x_ff; y_in = y_ff;
      arr_in = arr_ff; dl_in = dl_ff; dr_in = dr_ff; trav_in = trav_ff;
      ex_in = ex_ff; ey_in = ey_ff; sq_in = sq_ff; goal_dist = '0;
      sat_in = sat_ff; rsp_v_in = rsp_v_ff;
      mul_start = 1'b0; mul_a = '0; mul_b = '0; cor_start = 1'b0; sq_start = 1'b0;
      if (rsp_fire) rsp_v_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (req_fire) begin
            if (req_tuser) begin
               x_in = 32'(64'(start_x_ff) * (64'sd1 <<< FRAC_BITS));
               y_in = 32'(64'(start_y_ff) * (64'sd1 <<< FRAC_BITS));
               hd_in = start_hd_ff;
               arr_in = 1'b0;
               st_in = ST_POS;
            end else begin
               mul_start = 1'b1;
               mul_a = 64'(signed'(req_tdata[31:0] - prev_l_ff));
               mul_b = 34'(mpc_ff);
               st_in = ST_MUL1;
            end
         end
         ST_MUL1: if (mul_done) begin
            dl_in = 64'(mul_p);
            mul_start = 1'b1;
            mul_a = 64'(signed'(rc_ff - prev_r_ff));
            mul_b = 34'(mpc_ff);
            st_in = ST_MUL2;
         end
         ST_MUL2: if (mul_done) begin
            dr_in = 64'(mul_p);
            mul_start = 1'b1;
            mul_a = 64'(mul_p) - dl_ff;
            mul_b = 34'(gain_ff);
            st_in = ST_GAIN;
         end
         ST_GAIN: if (mul_done) begin
            mid_in = hd_ff + p_gain[29 +: ANGLE_BITS];
            hd_in  = hd_ff + p_gain[28 +: ANGLE_BITS];
            trav_in = trav_sat;
            cor_start = 1'b1;
            st_in = ST_TRIG;
         end
         ST_TRIG: if (cor_done) begin
            mul_start = 1'b1;
            mul_a = trav_ff;
            mul_b = cos_v;
            st_in = ST_MX;
         end
         ST_MX: if (mul_done) begin
            x_in = sat32(64'(x_ff) + pstep);
            mul_start = 1'b1;
            mul_a = trav_ff;
            mul_b = sin_v;
            st_in = ST_MY;
         end
         ST_MY: if (mul_done) begin
            y_in = sat32(64'(y_ff) + pstep);
            st_in = ST_POS;
         end
         ST_POS: begin
            ex_in = ex_s >>> (FRAC_BITS - DFRAC);
            ey_in = ey_s >>> (FRAC_BITS - DFRAC);
            st_in = ST_SQX;
            mul_start = 1'b1;
            mul_a = (ex_s >>> (FRAC_BITS - DFRAC)) < 0 ?
                    -(ex_s >>> (FRAC_BITS - DFRAC)) : (ex_s >>> (FRAC_BITS - DFRAC));
            mul_b = 34'(mul_a);
         end
         ST_SQX: if (mul_done) begin
            sq_in = 64'(mul_p);
            sat_in = (ax >= (64'sd1 <<< DLIM)) || (ay >= (64'sd1 <<< DLIM));
            mul_start = 1'b1;
            mul_a = ay;
            mul_b = 34'(ay);
            st_in = ST_SQY;
         end
         ST_SQY: if (mul_done) begin
            sq_in = sq_ff + 64'(mul_p);
            st_in = ST_ROOT;
         end
         ST_ROOT: begin
            sq_start = 1'b1;
            st_in = ST_OUT;
         end
         ST_OUT: if (sq_done) begin
            if (sat_ff || (root_v >> DFRAC) > 32'(DIST_MAX)) goal_dist = 17'(DIST_MAX);
            else goal_dist = 17'(root_v >> DFRAC);
            if ({15'd0, goal_dist} <= {16'd0, radius_ff}) arr_in = 1'b1;
            rsp_v_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Configuration and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         goal_x_ff <= 16'sd200; goal_y_ff <= 16'sd200;
         start_x_ff <= '0; start_y_ff <= '0;
         start_hd_ff <= ANGLE_BITS'(8192);
         mpc_ff <= 24'd5360; gain_ff <= 24'd806093; radius_ff <= 16'd10;
         prev_l_ff <= '0; prev_r_ff <= '0;
         x_ff <= '0; y_ff <= '0; hd_ff <= ANGLE_BITS'(8192);
         arr_ff <= 1'b0; rsp_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; x_ff <= x_in; y_ff <= y_in; hd_ff <= hd_in;
         arr_ff <= arr_in; rsp_v_ff <= rsp_v_in;
         // Advance the reference counts once the transaction is done
         if (st_ff == ST_OUT && sq_done) begin
            prev_l_ff <= lc_ff;
            prev_r_ff <= rc_ff;
         end
         if (csr_we) begin
            unique case (csr_idx)
               REG_GOAL_X:   goal_x_ff <= csr_wdata[15:0];
               REG_GOAL_Y:   goal_y_ff <= csr_wdata[15:0];
               REG_START_X:  start_x_ff <= csr_wdata[15:0];
               REG_START_Y:  start_y_ff <= csr_wdata[15:0];
               REG_START_HD: start_hd_ff <= csr_wdata[ANGLE_BITS-1:0];
               REG_MPC:      mpc_ff <= csr_wdata;
               REG_GAIN:     gain_ff <= csr_wdata;
               REG_RADIUS:   radius_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      if (req_fire) begin
         lc_ff <= req_tdata[31:0];
         rc_ff <= req_tdata[63:32];
      end
      mid_ff <= mid_in; dl_ff <= dl_in; dr_ff <= dr_in; trav_ff <= trav_in;
      ex_ff <= ex_in; ey_ff <= ey_in; sq_ff <= sq_in;
      sat_ff <= sat_in;
      if (st_ff == ST_OUT && sq_done) begin
         rsp_x_ff <= x_ff; rsp_y_ff <= y_ff; rsp_hd_ff <= hd_ff;
         rsp_d_ff <= goal_dist; rsp_a_ff <= arr_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = 104'({rsp_a_ff, rsp_d_ff, 16'(rsp_hd_ff), rsp_y_ff, rsp_x_ff});

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> !req_tready) else $error("accept while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !rsp_v_ff) else $error("response during work");
   a_arr_sticky: assert property (@(posedge clock) disable iff (reset)
      (arr_ff && !(req_fire && req_tuser)) |=> arr_ff) else $error("arrival lost");
endmodule

// File: src/ddo_serial_mul.sv
`timescale 1ns / 1ps
// Shift-and-add multiplier: one bit of the two's-complement multiplier per cycle.
module ddo_serial_mul #(
   parameter int A_BITS = 64,
   parameter int B_BITS = 24,
   parameter int P_BITS = 96
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [A_BITS-1:0] a,
   input  logic signed [B_BITS-1:0] b,
   output logic                     done,
   output logic signed [P_BITS-1:0] product
);
   localparam int CNT_BITS = $clog2(B_BITS + 1);

   logic signed [P_BITS-1:0] acc_ff, acc_in, mcd_ff, mcd_in;
   logic [B_BITS-1:0]        mlt_ff, mlt_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in;

   // Add the shifted multiplicand for each set multiplier bit
   always_comb begin
      acc_in  = acc_ff;
      mcd_in  = mcd_ff;
      mlt_in  = mlt_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mcd_in  = P_BITS'(a);
         mlt_in  = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The top multiplier bit carries negative weight
         if (mlt_ff[0]) begin
            if (cnt_ff == CNT_BITS'(B_BITS - 1)) acc_in = acc_ff - mcd_ff;
            else acc_in = acc_ff + mcd_ff;
         end
         mcd_in = mcd_ff <<< 1;
         mlt_in = mlt_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(B_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      mlt_ff <= mlt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// File: src/ddo_cordic.sv
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per cycle.
module ddo_cordic #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ANGLE_BITS-1:0]  angle,
   output logic                   done,
   output logic signed [33:0]     cos_q30,
   output logic signed [33:0]     sin_q30
);
   import ddo_pkg::*;
   localparam int STEPS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int CNT_BITS = 5;

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [31:0] u, uf;

   assign u  = {angle, {(32-ANGLE_BITS){1'b0}}};
   assign uf = u - 32'h80000000;

   // Fold into the right half plane, then iterate
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (start) begin
         x_in = 34'sd652032874;
         y_in = '0;
         if (u >= 32'h40000000 && u < 32'hC0000000) begin
            neg_in = 1'b1;
            z_in   = 34'(signed'(uf));
         end else begin
            neg_in = 1'b0;
            z_in   = 34'(signed'(u));
         end
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - (y_ff >>> cnt_ff);
            y_in = y_ff + (x_ff >>> cnt_ff);
            z_in = z_ff - 34'(atan_turn(cnt_ff));
         end else begin
            x_in = x_ff + (y_ff >>> cnt_ff);
            y_in = y_ff - (x_ff >>> cnt_ff);
            z_in = z_ff + 34'(atan_turn(cnt_ff));
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign done    = done_ff;
   assign cos_q30 = neg_ff ? -x_ff : x_ff;
   assign sin_q30 = neg_ff ? -y_ff : y_ff;
endmodule

// File: src/ddo_isqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit square root, two radicand bits per cycle.
module ddo_isqrt #(
   parameter int IN_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [IN_BITS-1:0]   radicand,
   output logic                 done,
   output logic [IN_BITS/2-1:0] root
);
   localparam int STEPS    = IN_BITS / 2;
   localparam int CNT_BITS = $clog2(STEPS + 1);

   logic [IN_BITS-1:0]   v_ff, v_in;
   logic [IN_BITS/2+1:0] rem_ff, rem_in, trial;
   logic [IN_BITS/2-1:0] r_ff, r_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [IN_BITS/2+1:0] rem_sh;

   assign rem_sh = {rem_ff[IN_BITS/2-1:0], v_ff[IN_BITS-1 -: 2]};
   assign trial  = {r_ff, 2'b01};

   // Take one root bit per step
   always_comb begin
      v_in = v_ff; rem_in = rem_ff; r_in = r_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         v_in = radicand; rem_in = '0; r_in = '0;
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = v_ff << 2;
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            r_in   = {r_ff[IN_BITS/2-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            r_in   = {r_ff[IN_BITS/2-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      rem_ff <= rem_in;
      r_ff   <= r_in;
   end

   assign done = done_ff;
   assign root = r_ff;
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import ddo_pkg::*;

   localparam int  CLK_HALF   = 10;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef enum logic { FN_SAMPLE = 1'b0, FN_RESTART = 1'b1 } odo_func_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] heading;
      logic [16:0] goal_distance;
      logic        arrived;
   } pose_report_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [63:0]   req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [103:0]  rsp_tdata;
   logic          csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_idx;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   differential_drive_odometry_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   // odometer copy: registers and pose
   logic [23:0]  odo_regs [8];
   logic [31:0]  last_left, last_right;
   int           pose_x, pose_y;
   logic [15:0]  pose_hd;
   bit           reached;

   pose_report_type pending_reports [$];
   int           fail_count;
   bit           send_gaps;
   bit           rsp_stalls;
   int           hold_req;
   longint       cycle_count;
   logic [31:0]  walk_left, walk_right;

   localparam logic [31:0] ATAN_TURN [16] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // cosine and sine in Q30 of a 16-bit binary angle
   function automatic void rotate_unit(input logic [15:0] ang, output longint c,
                                       output longint s);
      logic [31:0] u;
      bit          flip;
      longint      x, y, z, xs, ys;
      u = {ang, 16'h0};
      flip = 1'b0;
      if (u >= 32'h40000000 && u < 32'hC0000000) begin
         u = u - 32'h80000000;
         flip = 1'b1;
      end
      z = longint'($signed(u));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(ATAN_TURN[i]);
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(ATAN_TURN[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic [16:0] distance_to_goal();
      longint ex, ey;
      longint unsigned ax, ay, r;
      ex = longint'($signed(odo_regs[REG_GOAL_X][15:0])) * 256 - longint'(pose_x);
      ey = longint'($signed(odo_regs[REG_GOAL_Y][15:0])) * 256 - longint'(pose_y);
      ax = (ex < 0) ? -ex : ex;
      ay = (ey < 0) ? -ey : ey;
      if (ax >= (64'd1 << 25) || ay >= (64'd1 << 25)) return 17'(DIST_MAX);
      r = int_sqrt(ax * ax + ay * ay) >> 8;
      return (r > DIST_MAX) ? 17'(DIST_MAX) : 17'(r);
   endfunction

   // advance the pose for one accepted transaction and build its report
   function automatic pose_report_type advance_pose(odo_func_type fn, logic [31:0] lc,
                                                    logic [31:0] rc);
      pose_report_type rep;
      longint dl, dr, trav, c, s, mpc;
      longint unsigned p;
      logic [15:0] mid;
      logic [16:0] goal_mm;
      if (fn == FN_RESTART) begin
         pose_x  = int'($signed(odo_regs[REG_START_X][15:0])) * 256;
         pose_y  = int'($signed(odo_regs[REG_START_Y][15:0])) * 256;
         pose_hd = odo_regs[REG_START_HD][15:0];
         reached = 1'b0;
      end else begin
         mpc = longint'({40'h0, odo_regs[REG_MPC]});
         dl = longint'($signed(lc - last_left)) * mpc;
         dr = longint'($signed(rc - last_right)) * mpc;
         p = longint'(dr - dl) * longint'({40'h0, odo_regs[REG_GAIN]});
         mid = pose_hd + p[44:29];
         trav = (dl + dr) >>> 1;
         if (trav > (64'sd1 <<< 32) - 1) trav = (64'sd1 <<< 32) - 1;
         if (trav < -(64'sd1 <<< 32)) trav = -(64'sd1 <<< 32);
         rotate_unit(mid, c, s);
         pose_x = clamp32(longint'(pose_x) + ((trav * c + (64'sd1 <<< 37)) >>> 38));
         pose_y = clamp32(longint'(pose_y) + ((trav * s + (64'sd1 <<< 37)) >>> 38));
         pose_hd = pose_hd + p[43:28];
      end
      last_left  = lc;
      last_right = rc;
      goal_mm = distance_to_goal();
      if ({7'h0, goal_mm} <= odo_regs[REG_RADIUS]) reached = 1'b1;
      rep.pos_x = pose_x;
      rep.pos_y = pose_y;
      rep.heading = pose_hd;
      rep.goal_distance = goal_mm;
      rep.arrived = reached;
      return rep;
   endfunction

   // check each response against the oldest pending report
   always @(posedge clock) begin
      pose_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[31:0] !== want.pos_x) begin
               $error("pos_x exp %h got %h", want.pos_x, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[63:32] !== want.pos_y) begin
               $error("pos_y exp %h got %h", want.pos_y, rsp_tdata[63:32]);
               fail_count++;
            end
            if (rsp_tdata[79:64] !== want.heading) begin
               $error("heading exp %h got %h", want.heading, rsp_tdata[79:64]);
               fail_count++;
            end
            if (rsp_tdata[96:80] !== want.goal_distance) begin
               $error("goal_distance exp %0d got %0d", want.goal_distance,
                      rsp_tdata[96:80]);
               fail_count++;
            end
            if (rsp_tdata[97] !== want.arrived) begin
               $error("arrived exp %b got %b", want.arrived, rsp_tdata[97]);
               fail_count++;
            end
         end
      end
   end

   // response-side ready: long hold, random stall bursts, or always ready
   always @(posedge clock) begin
      int stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_req > 0) begin
         rsp_tready <= 1'b0;
         hold_req = hold_req - 1;
      end else if (!rsp_stalls) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // offer one item, hold it until accepted, then predict its report
   task automatic send_item(odo_func_type fn, logic [31:0] lc, logic [31:0] rc);
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {rc, lc};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(advance_pose(fn, lc, rc));
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [23:0] val);
      logic [23:0] masked;
      drain();
      masked = (idx == REG_MPC || idx == REG_GAIN) ? val : {8'h0, val[15:0]};
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      odo_regs[idx] = masked;
   endtask

   // sample along the current walk with random steps within +/- span
   task automatic walk_step(int span);
      walk_left  = walk_left + 32'($urandom_range(0, 2 * span) - span);
      walk_right = walk_right + 32'($urandom_range(0, 2 * span) - span);
      send_item(FN_SAMPLE, walk_left, walk_right);
   endtask

   task automatic test_directed();
      send_item(FN_SAMPLE, 32'd0, 32'd0);
      send_item(FN_SAMPLE, 32'd100, 32'd100);
      send_item(FN_SAMPLE, 32'd100, 32'd300);
      send_item(FN_SAMPLE, 32'd400, 32'd300);
      send_item(FN_SAMPLE, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(FN_SAMPLE, 32'h80000000, 32'h80000000);   // counts wrap
      send_item(FN_SAMPLE, 32'h80000000, 32'h7FFFFFFF);
      send_item(FN_SAMPLE, 32'hFFFFFFFF, 32'h00000000);
      send_item(FN_RESTART, 32'h12345678, 32'h9ABCDEF0);
      send_item(FN_SAMPLE, 32'h12345678, 32'h9ABCDEF0);
      send_item(FN_SAMPLE, 32'h12345678 + 32'd1000, 32'h9ABCDEF0 + 32'd1000);
      send_item(FN_RESTART, 32'hFFFFFFFF, 32'hFFFFFFFF);
      // drive straight toward the default goal at (200, 200)
      for (int i = 1; i <= 8; i++)
         send_item(FN_SAMPLE, 32'hFFFFFFFF + 32'(i * 8), 32'hFFFFFFFF + 32'(i * 8));
      drain();
   endtask

   task automatic test_register_extremes();
      write_reg(REG_MPC, 24'hFFFFFF);
      write_reg(REG_GAIN, 24'hFFFFFF);
      write_reg(REG_START_HD, 24'h00FFFF);
      write_reg(REG_START_X, 24'h007FFF);
      write_reg(REG_START_Y, 24'h008000);
      write_reg(REG_GOAL_X, 24'h008000);
      write_reg(REG_GOAL_Y, 24'h007FFF);
      write_reg(REG_RADIUS, 24'h00FFFF);
      send_item(FN_RESTART, 32'd0, 32'd0);
      send_item(FN_SAMPLE, 32'h7FFFFFFF, 32'h80000000);   // wheels step in opposite directions
      send_item(FN_SAMPLE, 32'h00000000, 32'h00000000);
      send_item(FN_SAMPLE, 32'h80000000, 32'h80000000);
      for (int i = 0; i < 4; i++) send_item(FN_SAMPLE, $urandom, $urandom);
      write_reg(REG_MPC, 24'h0);
      write_reg(REG_GAIN, 24'h0);
      write_reg(REG_RADIUS, 24'h0);
      write_reg(REG_START_HD, 24'h0);
      write_reg(REG_START_X, 24'h00C8);
      write_reg(REG_START_Y, 24'h007FFF);
      write_reg(REG_GOAL_X, 24'h00C8);
      write_reg(REG_GOAL_Y, 24'h007FFF);
      send_item(FN_RESTART, 32'd5, 32'd5);                // lands on the goal
      send_item(FN_SAMPLE, 32'd900, 32'd9000);
      write_reg(REG_MPC, 24'd5360);
      write_reg(REG_GAIN, 24'd806093);
      write_reg(REG_RADIUS, 24'd10);
      write_reg(REG_START_HD, 24'h004000);
      write_reg(REG_START_X, 24'h0);
      write_reg(REG_START_Y, 24'h0);
      write_reg(REG_GOAL_X, 24'd200);
      write_reg(REG_GOAL_Y, 24'd200);
      walk_left = 32'd0;
      walk_right = 32'd0;
      send_item(FN_RESTART, walk_left, walk_right);
   endtask

   // requests stall while the response side is held off
   task automatic test_backpressure();
      drain();
      hold_req = 400;
      for (int i = 0; i < 6; i++) walk_step(300);
      drain();
   endtask

   task automatic random_config();
      case ($urandom_range(0, 3))
         0: write_reg(REG_MPC, 24'($urandom_range(1000, 20000)));
         1: write_reg(REG_GAIN, 24'($urandom));
         2: write_reg(REG_RADIUS, 24'($urandom_range(0, 3) == 0 ? $urandom : 500));
         default: begin
            write_reg(REG_GOAL_X, 24'($urandom_range(0, 1) ? $urandom : 300));
            write_reg(REG_GOAL_Y, 24'($urandom_range(0, 1) ? $urandom : 100));
            write_reg(REG_START_X, 24'($urandom_range(0, 3) == 0 ? $urandom : 250));
            write_reg(REG_START_Y, 24'($urandom_range(0, 3) == 0 ? $urandom : 80));
            write_reg(REG_START_HD, 24'($urandom));
         end
      endcase
   endtask

   task automatic test_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 149) random_config();
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_item(FN_RESTART, walk_left, walk_right);
         end else if (pick < 12) begin
            walk_left = $urandom;
            walk_right = $urandom;
            send_item(odo_func_type'($urandom_range(0, 1)), walk_left, walk_right);
         end else if (pick < 20) begin
            walk_step(100000);
         end else begin
            walk_step(200);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      fail_count = 0;
      hold_req = 0;
      send_gaps = 1'b1;
      rsp_stalls = 1'b1;
      odo_regs = '{24'd200, 24'd200, 24'd0, 24'd0, 24'd8192, 24'd5360, 24'd806093, 24'd10};
      last_left = '0;
      last_right = '0;
      pose_x = 0;
      pose_y = 0;
      pose_hd = 16'd8192;
      reached = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random(1700);
      // last part runs without idling on either side
      drain();
      send_gaps = 1'b0;
      rsp_stalls = 1'b0;
      test_random(200);
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
